// ===== design/gbaqi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbaqi_pkg;
  localparam int SlotCount = 15;
  localparam int SlotW = $clog2(SlotCount);
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 22;
  localparam logic [CfgIdxW-1:0] CfgWarmup = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFloor = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSlotLen = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd3;
  localparam logic [2:0] ClassGood = 3'd0;
  localparam logic [2:0] ClassModerate = 3'd1;
  localparam logic [2:0] ClassPoor = 3'd2;
  localparam logic [2:0] ClassBad = 3'd3;
  localparam logic [2:0] ClassWarmup = 3'd4;
  localparam int DivSteps = 16;

  typedef struct packed {
    logic load;
    logic slot_update;
    logic scan;
    logic seed;
    logic div_start;
    logic div_step;
    logic score;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic scan_last;
    logic score_ok;
    logic div_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/gbaqi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbaqi_ctrl
  import gbaqi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  wire logic out_free_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      out_load_o
);
  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StUpd = 7'b0000010, StScan = 7'b0000100,
    StSeed = 7'b0001000, StDiv = 7'b0010000, StScore = 7'b0100000,
    StOut = 7'b1000000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_fire_i;
        if (in_fire_i) state_d = StUpd;
      end
      StUpd: begin
        if (sts_i.accepted) begin
          cmd_o.slot_update = 1'b1;
          state_d = StScan;
        end else begin
          state_d = StOut;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = StSeed;
      end
      StSeed: begin
        cmd_o.seed = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (!sts_i.score_ok) begin
          state_d = StOut;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StScore;
        end
      end
      StScore: begin
        cmd_o.div_step = !sts_i.div_last;
        if (sts_i.div_last) begin
          cmd_o.score = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = state_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle) else $error("load while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.score |=> state_q == StOut) else $error("score not followed by output");
endmodule
`default_nettype wire

// ===== design/gbaqi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbaqi_datapath
  import gbaqi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [31:0]         time_i,
  input  wire logic signed [14:0]  temp_i,
  input  wire logic signed [14:0]  hum_i,
  input  wire logic [16:0]         pres_i,
  input  wire logic [23:0]         gas_i,
  output logic                     accepted_o,
  output logic                     present_o,
  output logic [6:0]               score_o,
  output logic [23:0]              baseline_o
);
  logic [15:0] warm_q, floor_q;
  logic [19:0] slen_q;
  logic [21:0] win_q;
  logic [31:0] now_q;
  logic signed [14:0] hum_q;
  logic [23:0] gas_q;
  logic acc_q;
  logic [23:0] peak_q [SlotCount];
  logic [31:0] start_q [SlotCount];
  logic [SlotCount-1:0] open_q;
  logic [SlotW-1:0] ptr_q, scan_q;
  logic [23:0] best_q, base_q;
  logic [6:0] held_q;
  logic present_q;
  logic [23:0] rem_q;
  logic [16:0] quo_q;
  logic [5:0] dcnt_q;

  logic acc_d;
  logic [31:0] age_cur, age_scan;
  logic [SlotW-1:0] ptr_nx;
  logic [24:0] rem_sh;
  logic [16:0] r;
  logic [23:0] gs;
  logic [12:0] hum_hi;
  logic [11:0] hum_lo;
  logic [38:0] hum_hi_p;
  logic [34:0] hum_lo_p;
  logic [20:0] hs;
  logic [24:0] tot;
  logic [6:0] sc;

  assign acc_d = temp_i >= -15'sd4000 && temp_i <= 15'sd10000 && hum_i >= 15'sd0
    && hum_i <= 15'sd10000 && pres_i >= 17'd20000 && pres_i <= 17'd120000;
  assign age_cur = now_q - start_q[ptr_q];
  assign age_scan = now_q - start_q[scan_q];
  assign ptr_nx = (ptr_q == SlotW'(SlotCount - 1)) ? '0 : ptr_q + 1'b1;
  assign rem_sh = {rem_q, 1'b0};

  // The humidity terms are d * 4096 / 15 and h * 2048 / 5, formed by reciprocal
  // multiplication that is exact over the accepted humidity range.
  always_comb begin
    r = (quo_q > 17'd65536) ? 17'd65536 : quo_q;
    if (r >= 17'd58982) gs = 24'(75 * 65536);
    else if (r >= 17'd45875) gs = 24'(55 * 65536) + 24'(r - 17'd45875) * 24'd100;
    else if (r >= 17'd29491) gs = 24'(30 * 65536) + 24'(r - 17'd29491) * 24'd100;
    else if (r >= 17'd13107) gs = 24'(5 * 65536) + 24'(r - 17'd13107) * 24'd100;
    else gs = '0;
    hum_hi = 13'(15'sd10000 - hum_q);
    hum_lo = 12'(hum_q);
    hum_hi_p = 39'(hum_hi) * 39'd35791395;
    hum_lo_p = 35'(hum_lo) * 35'd6710887;
    if (hum_q >= 15'sd4000) hs = hum_hi_p[37:17];
    else hs = hum_lo_p[34:14];
    tot = 25'(gs) + 25'(hs);
    sc = (tot[24:16] > 9'd100) ? 7'd100 : tot[22:16];
  end

  assign sts_o.accepted = acc_q;
  assign sts_o.scan_last = scan_q == SlotW'(SlotCount - 1);
  assign sts_o.score_ok = now_q >= 32'(warm_q) && gas_q >= 24'(floor_q)
    && base_q >= 24'(floor_q) && base_q != '0;
  assign sts_o.div_last = dcnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= 16'd15000;
      floor_q <= 16'd1500;
      slen_q <= 20'd120000;
      win_q <= 22'd1800000;
      open_q <= '0;
      ptr_q <= '0;
      base_q <= '0;
      held_q <= '0;
      present_q <= 1'b0;
      acc_q <= 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
        peak_q[i] <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWarmup: warm_q <= cfg_data_i[15:0];
          CfgFloor: floor_q <= cfg_data_i[15:0];
          CfgSlotLen: slen_q <= cfg_data_i[19:0];
          CfgWindow: win_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) acc_q <= acc_d;
      if (cmd_i.slot_update) begin
        if (age_cur >= 32'(slen_q)) begin
          ptr_q <= ptr_nx;
          peak_q[ptr_nx] <= gas_q;
          start_q[ptr_nx] <= now_q;
          open_q[ptr_nx] <= 1'b1;
        end else if (gas_q > peak_q[ptr_q]) begin
          peak_q[ptr_q] <= gas_q;
        end
      end
      if (cmd_i.seed) begin
        if (best_q > 24'(floor_q)) begin
          if (!(best_q < 24'(floor_q) && gas_q > 24'(floor_q))) base_q <= best_q;
        end else if (base_q < 24'(floor_q) && gas_q > 24'(floor_q)) begin
          base_q <= gas_q;
        end
      end
      if (cmd_i.score) begin
        held_q <= sc;
        present_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= time_i;
      hum_q <= hum_i;
      gas_q <= gas_i;
    end
    if (cmd_i.slot_update) begin
      scan_q <= '0;
      best_q <= '0;
    end else if (cmd_i.scan) begin
      if (open_q[scan_q] && age_scan <= 32'(win_q) && peak_q[scan_q] > best_q)
        best_q <= peak_q[scan_q];
      if (scan_q != SlotW'(SlotCount - 1)) scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      rem_q <= gas_q;
      quo_q <= (gas_q >= base_q) ? 17'd65536 : 17'd0;
      dcnt_q <= 6'(DivSteps);
    end else if (cmd_i.div_step) begin
      if (!quo_q[16]) begin
        if (rem_sh >= {1'b0, base_q}) begin
          rem_q <= 24'(rem_sh - {1'b0, base_q});
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_sh[23:0];
          quo_q <= {quo_q[15:0], 1'b0};
        end
      end
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  assign accepted_o = acc_q;
  assign present_o = present_q;
  assign score_o = held_q;
  assign baseline_o = base_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.score |-> base_q != '0) else $error("score with zero baseline");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q |-> held_q <= 7'd100) else $error("score above range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(present_q) |-> 1'b0) else $error("held score lost");
endmodule
`default_nettype wire

// ===== design/gas_baseline_air_quality_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A reading that yields a new score passes through slot update, slot scan, baseline seed,
// divide start, the 16-step ratio divide and score, and output load. Without a new score it
// skips the divide and score, and a rejected reading goes from slot update to output load.
// Throughput: one word at a time; the next word is taken the cycle after the result is loaded,
// and that load waits while the result register is full and not being read.
// Reset clears the slots, baseline and held score and loads the register defaults.
module gas_baseline_air_quality_index
  import gbaqi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // time_ms, temperature_centi, humidity_centi, pressure_pa, gas_ohms, zero pad
  input  wire logic [103:0]        s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // sample_accepted, score_valid, quality_score, quality_class, baseline_ohms, zero pad
  output logic [39:0]              m_axis_tdata
);
  cmd_t cmd;
  sts_t sts;
  logic busy, out_load, acc, present;
  logic [6:0] score;
  logic [23:0] base;
  logic [2:0] cls;
  logic [39:0] out_q;
  logic ov_q;

  assign s_axis_tready = !busy;

  gbaqi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .out_free_i(!ov_q || m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .out_load_o(out_load)
  );

  gbaqi_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .time_i(s_axis_tdata[31:0]), .temp_i(s_axis_tdata[46:32]),
    .hum_i(s_axis_tdata[61:47]), .pres_i(s_axis_tdata[78:62]),
    .gas_i(s_axis_tdata[102:79]),
    .accepted_o(acc), .present_o(present), .score_o(score), .baseline_o(base)
  );

  always_comb begin
    priority if (!present) cls = ClassWarmup;
    else if (score >= 7'd75) cls = ClassGood;
    else if (score >= 7'd55) cls = ClassModerate;
    else if (score >= 7'd35) cls = ClassPoor;
    else cls = ClassBad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= {4'd0, base, cls, present ? score : 7'd0, present, acc};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;
endmodule
`default_nettype wire
